>>> src/sefr_pkg.sv
package sefr_pkg;

	localparam int LOCAL_SLOTS = 4;
	localparam int PORT_SLOTS  = 8;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [2:0] CFG_START_CODE  = 3'd0;
	localparam logic [2:0] CFG_END_CODE    = 3'd1;
	localparam logic [2:0] CFG_LOCAL_ADDRS = 3'd2;
	localparam logic [2:0] CFG_LOCAL_COUNT = 3'd3;
	localparam logic [2:0] CFG_PORT_ADDRS  = 3'd4;
	localparam logic [2:0] CFG_PORT_COUNT  = 3'd5;

	typedef enum logic [1:0] {
		ROUTE_LOCAL   = 2'd0,
		ROUTE_PORT0   = 2'd1,
		ROUTE_UNKNOWN = 2'd2,
		ROUTE_BAD_END = 2'd3
	} route_t;

	typedef struct packed {
		logic [7:0]  start_code;
		logic [7:0]  end_code;
		logic [31:0] local_addresses;
		logic [2:0]  local_count;
		logic [63:0] port_addresses;
		logic [3:0]  port_count;
	} cfg_t;

	// one captured frame as it travels from framer to router
	typedef struct packed {
		logic [7:0] data_high;
		logic [7:0] data_low;
		logic [7:0] command;
		logic [7:0] destination;
		logic [7:0] source;
		logic       bad_end;
	} frame_t;

	// only four slots are checked, so a count above four acts as four: the address register is 32 bits only
	function automatic logic local_hit(cfg_t c, logic [7:0] addr);
		logic [63:0] packed_addrs;
		logic        hit;
		packed_addrs = {32'd0, c.local_addresses};
		hit = 1'b0;
		for (int i = 0; i < LOCAL_SLOTS; i++) begin
			if ((4'(i) < {1'b0, c.local_count}) && (packed_addrs[8*i +: 8] == addr))
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic port_hit(cfg_t c, logic [7:0] addr);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < PORT_SLOTS; i++) begin
			if ((4'(i) < c.port_count) && (c.port_addresses[8*i +: 8] == addr))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

>>> src/sefr_framer.sv
module sefr_framer import sefr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       push,
	output frame_t     push_frame
);

	typedef enum logic [6:0] {
		PH_HUNT = 7'b0000001,
		PH_SRC  = 7'b0000010,
		PH_DST  = 7'b0000100,
		PH_CMD  = 7'b0001000,
		PH_DLO  = 7'b0010000,
		PH_DHI  = 7'b0100000,
		PH_TRL  = 7'b1000000
	} phase_t;

	phase_t     phase_q;
	logic [7:0] src_q, dst_q, cmd_q, dlo_q, dhi_q;
	logic       take;

	// only the trailer needs room in the queue
	assign in_ready = (phase_q != PH_TRL) || !q_full;
	assign take     = in_valid && in_ready;
	assign push     = take && (phase_q == PH_TRL);

	always_comb begin
		push_frame.source      = src_q;
		push_frame.destination = dst_q;
		push_frame.command     = cmd_q;
		push_frame.data_low    = dlo_q;
		push_frame.data_high   = dhi_q;
		push_frame.bad_end     = (rx_byte != cfg.end_code);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (take) begin
			unique case (phase_q)
				PH_HUNT: phase_q <= (rx_byte == cfg.start_code) ? PH_SRC : PH_HUNT;
				PH_SRC:  phase_q <= PH_DST;
				PH_DST:  phase_q <= PH_CMD;
				PH_CMD:  phase_q <= PH_DLO;
				PH_DLO:  phase_q <= PH_DHI;
				PH_DHI:  phase_q <= PH_TRL;
				PH_TRL:  phase_q <= PH_HUNT;
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (phase_q == PH_SRC) src_q <= rx_byte;
			if (phase_q == PH_DST) dst_q <= rx_byte;
			if (phase_q == PH_CMD) cmd_q <= rx_byte;
			if (phase_q == PH_DLO) dlo_q <= rx_byte;
			if (phase_q == PH_DHI) dhi_q <= rx_byte;
		end
	end

endmodule

>>> src/sefr_queue.sv
module sefr_queue import sefr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output frame_t head_frame
);

	frame_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_frame = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_frame;
	end

endmodule

>>> src/sefr_router.sv
module sefr_router import sefr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       head_valid,
	input  frame_t     head_frame,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] source,
	output logic [7:0] destination,
	output logic [7:0] command,
	output logic [7:0] data_low,
	output logic [7:0] data_high,
	output logic [1:0] route
);

	logic   out_valid_q;
	frame_t frame_q;
	route_t route_q;
	route_t route_d;

	assign pop = head_valid && (!out_valid_q || out_ready);

	// bad trailer wins, then local slots, then port slots
	always_comb begin
		if (head_frame.bad_end)
			route_d = ROUTE_BAD_END;
		else if (local_hit(cfg, head_frame.destination))
			route_d = ROUTE_LOCAL;
		else if (port_hit(cfg, head_frame.destination))
			route_d = ROUTE_PORT0;
		else
			route_d = ROUTE_UNKNOWN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= head_frame;
			route_q <= route_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign source      = frame_q.source;
	assign destination = frame_q.destination;
	assign command     = frame_q.command;
	assign data_low    = frame_q.data_low;
	assign data_high   = frame_q.data_high;
	assign route       = route_q;

endmodule

>>> src/start_end_frame_router_unit.sv
// Framed byte receiver with destination routing.
// Input channel (in_valid/in_ready, rx_byte): one received byte per item.
// Bytes are dropped until one equals start_code; the next six bytes form a
// frame (source, destination, command, data_low, data_high, trailer).
// Output channel (out_valid/out_ready): one item per frame, carrying the five
// captured bytes and route (local, port 0, unknown, or bad end byte).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while the block is idle. The config registers reset to zero.
// Throughput: one byte per cycle, except while a trailer waits for queue space.
// After the trailer is accepted, the frame is held first in the frame queue,
// then in the router's output register, which drives the result.
// When the receiver stalls, the output register holds its item, the queue
// fills, and in_ready drops only while a trailer waits for queue space.
// Reset (arst_n low) returns the framer to hunting and empties queue and output.
module start_end_frame_router_unit import sefr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  source,
	output logic [7:0]  destination,
	output logic [7:0]  command,
	output logic [7:0]  data_low,
	output logic [7:0]  data_high,
	output logic [1:0]  route,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t   cfg_q;
	logic   q_full, push, pop, head_valid;
	frame_t push_frame, head_frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_CODE:  cfg_q.start_code      <= cfg_data[7:0];
				CFG_END_CODE:    cfg_q.end_code        <= cfg_data[7:0];
				CFG_LOCAL_ADDRS: cfg_q.local_addresses <= cfg_data[31:0];
				CFG_LOCAL_COUNT: cfg_q.local_count     <= cfg_data[2:0];
				CFG_PORT_ADDRS:  cfg_q.port_addresses  <= cfg_data;
				CFG_PORT_COUNT:  cfg_q.port_count      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	sefr_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_frame (push_frame)
	);

	sefr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_frame (head_frame)
	);

	sefr_router u_router (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_frame  (head_frame),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.source      (source),
		.destination (destination),
		.command     (command),
		.data_low    (data_low),
		.data_high   (data_high),
		.route       (route)
	);

endmodule

>>> dv/start_end_frame_router_unit_tb.sv
module start_end_frame_router_unit_tb;
	import sefr_pkg::*;

	localparam int TRAILER_PHASE = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_BYTES   = 190;
	localparam int RAND_PHASES   = 8;
	localparam int SETTLE_CYCLES = 10;
	localparam int LIMIT_CYCLES  = 400000;

	typedef struct {
		logic [7:0] source;
		logic [7:0] destination;
		logic [7:0] command;
		logic [7:0] data_low;
		logic [7:0] data_high;
		route_t     route;
	} frame_exp_t;

	class frame_scoreboard;
		bit [7:0]  start_code;
		bit [7:0]  end_code;
		bit [31:0] local_addrs;
		bit [2:0]  local_count;
		bit [63:0] port_addrs;
		bit [3:0]  port_count;
		bit [2:0]  phase;
		bit [39:0] fields;
		frame_exp_t pending_frames[$];
		int errors;

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				CFG_START_CODE:  start_code  = val[7:0];
				CFG_END_CODE:    end_code    = val[7:0];
				CFG_LOCAL_ADDRS: local_addrs = val[31:0];
				CFG_LOCAL_COUNT: local_count = val[2:0];
				CFG_PORT_ADDRS:  port_addrs  = val;
				CFG_PORT_COUNT:  port_count  = val[3:0];
				default: ;
			endcase
		endfunction

		function bit mid_frame();
			return phase != 0;
		endfunction

		// counts above the slot number saturate, so no local slot past the register is checked
		function route_t route_for(bit [7:0] dest, bit bad_end);
			int n;
			if (bad_end)
				return ROUTE_BAD_END;
			n = (local_count < LOCAL_SLOTS) ? local_count : LOCAL_SLOTS;
			for (int i = 0; i < n; i++) begin
				if (i < 4 && local_addrs[8*i +: 8] == dest)
					return ROUTE_LOCAL;
				if (i >= 4 && dest == 8'd0)
					return ROUTE_LOCAL;
			end
			n = (port_count < PORT_SLOTS) ? port_count : PORT_SLOTS;
			for (int i = 0; i < n && i < 8; i++) begin
				if (port_addrs[8*i +: 8] == dest)
					return ROUTE_PORT0;
			end
			return ROUTE_UNKNOWN;
		endfunction

		function void note_rx_byte(bit [7:0] b);
			frame_exp_t f;
			if (phase == 0 || phase > TRAILER_PHASE) begin
				if (b == start_code) begin
					phase = 1;
					fields = '0;
				end else begin
					phase = 0;
				end
			end else if (phase < TRAILER_PHASE) begin
				fields[8*(int'(phase) - 1) +: 8] = b;
				phase = phase + 3'd1;
			end else begin
				f.source      = fields[7:0];
				f.destination = fields[15:8];
				f.command     = fields[23:16];
				f.data_low    = fields[31:24];
				f.data_high   = fields[39:32];
				f.route       = route_for(fields[15:8], b != end_code);
				pending_frames.push_back(f);
				phase = 0;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("%0t: mismatch: %s", $time, msg);
		endtask

		task cmp_byte(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s got %02h want %02h", name, got, want));
		endtask

		task check_frame(frame_exp_t got);
			frame_exp_t want;
			if (pending_frames.size() == 0) begin
				report($sformatf("unexpected item src %02h dst %02h route %0d",
					got.source, got.destination, got.route));
				return;
			end
			want = pending_frames.pop_front();
			cmp_byte("source", got.source, want.source);
			cmp_byte("destination", got.destination, want.destination);
			cmp_byte("command", got.command, want.command);
			cmp_byte("data_low", got.data_low, want.data_low);
			cmp_byte("data_high", got.data_high, want.data_high);
			if (got.route !== want.route)
				report($sformatf("route got %0d want %s (dst %02h)",
					got.route, want.route.name(), want.destination));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  source;
	logic [7:0]  destination;
	logic [7:0]  command;
	logic [7:0]  data_low;
	logic [7:0]  data_high;
	logic [1:0]  route;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	bit no_idle;
	bit hold_req;
	frame_scoreboard sb;

	start_end_frame_router_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.source      (source),
		.destination (destination),
		.command     (command),
		.data_low    (data_low),
		.data_high   (data_high),
		.route       (route),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	task cfg_write(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task program_all(bit [7:0] s, bit [7:0] e, bit [31:0] la, bit [2:0] lc,
			bit [63:0] pa, bit [3:0] pc);
		cfg_write(CFG_START_CODE, {56'd0, s});
		cfg_write(CFG_END_CODE, {56'd0, e});
		cfg_write(CFG_LOCAL_ADDRS, {32'd0, la});
		cfg_write(CFG_LOCAL_COUNT, {61'd0, lc});
		cfg_write(CFG_PORT_ADDRS, pa);
		cfg_write(CFG_PORT_COUNT, {60'd0, pc});
	endtask

	task send_byte(bit [7:0] b);
		if (!no_idle) begin
			while ($urandom_range(99) < 27) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (!in_ready);
		sb.note_rx_byte(b);
	endtask

	task send_frame();
		bit [63:0] slots;
		bit [7:0]  dest;
		int        pick;
		pick = $urandom_range(99);
		if (pick < 40)
			slots = {32'd0, sb.local_addrs} >> (8 * $urandom_range(7));
		else if (pick < 70)
			slots = sb.port_addrs >> (8 * $urandom_range(7));
		else
			slots = {56'd0, 8'($urandom)};
		dest = slots[7:0];
		send_byte(sb.start_code);
		send_byte(8'($urandom));
		send_byte(dest);
		repeat (3) send_byte(8'($urandom));
		send_byte(($urandom_range(99) < 85) ? sb.end_code : 8'($urandom));
	endtask

	// finish any open frame, then let the queue empty before touching registers
	task drain();
		while (sb.mid_frame())
			send_byte(8'($urandom));
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin : result_monitor
		frame_exp_t got;
		if (arst_n && out_valid && out_ready) begin
			got.source      = source;
			got.destination = destination;
			got.command     = command;
			got.data_low    = data_low;
			got.data_high   = data_high;
			got.route       = route_t'(route);
			sb.check_frame(got);
		end
	end

	initial begin
		#(4 * LIMIT_CYCLES);
		$display("start_end_frame_router_unit_tb: FAIL");
		$finish;
	end

	initial begin
		int sent;
		int n;
		in_valid  = 1'b0;
		rx_byte   = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_START_CODE;
		cfg_data  = 64'd0;
		no_idle   = 1'b0;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: local beats port on a shared address, start code as a frame byte,
		// bad trailer over a local hit, unknown destination
		program_all(8'hA5, 8'h5A, 32'h4030_2010, 3'd4, 64'h8877_6655_4433_2210, 4'd8);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5); send_byte(8'hFF); send_byte(8'h10); send_byte(8'hA5);
		send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A);
		send_byte(8'hA5); send_byte(8'h00); send_byte(8'h88); send_byte(8'h01);
		send_byte(8'h80); send_byte(8'h7F); send_byte(8'h5A);
		send_byte(8'hA5); send_byte(8'h12); send_byte(8'h10); send_byte(8'h34);
		send_byte(8'h56); send_byte(8'h78); send_byte(8'hFF);
		send_byte(8'hA5); send_byte(8'h00); send_byte(8'h99); send_byte(8'hFF);
		send_byte(8'hFF); send_byte(8'h00); send_byte(8'h5A);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				program_all(8'h00, 8'h00, 32'd0, 3'd0, 64'd0, 4'd0);
			else if (ph == 1)
				program_all(8'hFF, 8'hFF, 32'hFFFF_FFFF, 3'd7, {64{1'b1}}, 4'd15);
			else
				program_all(8'($urandom), 8'($urandom), 32'($urandom),
					3'($urandom_range(7)), {32'($urandom), 32'($urandom)},
					4'($urandom_range(15)));
			no_idle = (ph == 2);
			if (ph == 3 || ph == 6)
				hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				if ($urandom_range(99) < 15) begin
					n = $urandom_range(1, 5);
					repeat (n) send_byte(8'($urandom));
				end else begin
					send_frame();
					sent += 7;
				end
			end
			drain();
			no_idle = 1'b0;
		end

		if (sb.errors == 0)
			$display("start_end_frame_router_unit_tb: PASS");
		else
			$display("start_end_frame_router_unit_tb: FAIL");
		$finish;
	end

endmodule
